### rtl/core/pmfa_pkg.sv
// ----------------------------------------------------------------------------
// Pulse meter fill alarm package
// Shared widths, request and register codes, reset values and the command
// and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package pmfa_pkg;

    // Default number of counted channels.
    localparam int NUM_CHANNELS = 5;
    // Number of count fields in one result.
    localparam int NUM_COUNT_FIELDS = 5;

    // Field widths.
    localparam int REQ_W      = 2;
    localparam int CH_W       = 3;
    localparam int CNT_W      = 32;
    localparam int RDIV_W     = 16;
    localparam int THR_W      = 31;
    localparam int BDIV_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Request types carried by req_type.
    typedef enum logic [REQ_W-1:0] {
        REQ_PULSE  = 2'd0,
        REQ_UPDATE = 2'd1,
        REQ_BEEP   = 2'd2
    } t_req_type;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FLOW_CH    = 2'd0,
        CFG_REPORT_DIV = 2'd1,
        CFG_FILL_THR   = 2'd2,
        CFG_BEEP_DIV   = 2'd3
    } t_cfg_idx;

    // Configuration reset values.
    localparam logic [CH_W-1:0]   RST_FLOW_CH    = 3'd0;
    localparam logic [RDIV_W-1:0] RST_REPORT_DIV = 16'd10;
    localparam logic [THR_W-1:0]  RST_FILL_THR   = 31'd1000;
    localparam logic [BDIV_W-1:0] RST_BEEP_DIV   = 8'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;
        logic div_done;
    } t_sts;

endpackage

### rtl/core/pmfa_if.sv
// ----------------------------------------------------------------------------
// Pulse meter fill alarm channels
// Request, result and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------

// Request channel: one pulse or tick per request.
interface pmfa_req_if;
    logic                         valid;
    logic                         ready;
    logic [pmfa_pkg::REQ_W-1:0]   req_type;
    logic [pmfa_pkg::CH_W-1:0]    channel;

    modport source (output valid, req_type, channel, input ready);
    modport sink   (input valid, req_type, channel, output ready);
endinterface

// Result channel: one result per request.
interface pmfa_res_if;
    logic                         valid;
    logic                         ready;
    logic                         report_due;
    logic                         full_res;
    logic                         beep_on;
    logic [pmfa_pkg::CNT_W-1:0]   count_a;
    logic [pmfa_pkg::CNT_W-1:0]   count_b;
    logic [pmfa_pkg::CNT_W-1:0]   count_c;
    logic [pmfa_pkg::CNT_W-1:0]   count_d;
    logic [pmfa_pkg::CNT_W-1:0]   count_e;

    modport source (output valid, report_due, full_res, beep_on,
                    count_a, count_b, count_c, count_d, count_e, input ready);
    modport sink   (input valid, report_due, full_res, beep_on,
                    count_a, count_b, count_c, count_d, count_e, output ready);
endinterface

// Configuration write channel.
interface pmfa_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [pmfa_pkg::CFG_IDX_W-1:0]   reg_index;
    logic [pmfa_pkg::CFG_DATA_W-1:0]  wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

### rtl/core/pulse_meter_fill_alarm.sv
// ----------------------------------------------------------------------------
// Pulse meter fill alarm
// Counts meter pulses per channel, tracks container filling on the flow
// channel, hands out report requests and drives an alarm toggle pattern.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request: a pulse on a channel, an update tick or a
//   beep tick. Every request gives exactly one result on o_res, holding the
//   report request (update ticks only), the full state, the alarm drive and
//   the five channel counts after the request.
//   i_cfg writes the flow channel, report divider, fill threshold and beep
//   divider; it is ready whenever reset is released. The user writes it only
//   while the block is idle; the block itself does not enforce this.
//   A request is accepted, captured, executed and its result loaded into the
//   output register. A pulse on the flow channel with a nonzero report
//   divider first waits for the bit-serial remainder unit, which runs
//   32 steps to check the new count against the divider.
//   One request is in work at a time; the next is accepted once the result
//   is in the output register, even while that result still waits.
//   A stalled receiver holds the result and its valid; a finished request
//   waits to load until the output register is free.
//   Reset clears all counts and the fill and alarm state and restores the
//   register defaults; no request is accepted during reset.
// ----------------------------------------------------------------------------
module pulse_meter_fill_alarm #(
    parameter int NUM_CHANNELS = pmfa_pkg::NUM_CHANNELS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pmfa_req_if.sink       i_req,
    pmfa_res_if.source     o_res,
    pmfa_cfg_if.sink       i_cfg
);

    pmfa_pkg::t_cmd                 w_cmd;
    pmfa_pkg::t_sts                 w_sts;
    logic [pmfa_pkg::CNT_W-1:0]     w_counts [pmfa_pkg::NUM_COUNT_FIELDS];

    // Configuration writes are taken at any time outside reset.
    assign i_cfg.ready = i_rst_n;

    pmfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    pmfa_dp #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_req_type   (i_req.req_type),
        .i_channel    (i_req.channel),
        .i_cfg_we     (i_cfg.valid && i_cfg.ready),
        .i_cfg_index  (i_cfg.reg_index),
        .i_cfg_wdata  (i_cfg.wdata),
        .o_report_due (o_res.report_due),
        .o_full_res   (o_res.full_res),
        .o_beep_on    (o_res.beep_on),
        .o_counts     (w_counts)
    );

    // Count fields in channel order.
    assign o_res.count_a = w_counts[0];
    assign o_res.count_b = w_counts[1];
    assign o_res.count_c = w_counts[2];
    assign o_res.count_d = w_counts[3];
    assign o_res.count_e = w_counts[4];

endmodule

### rtl/core/pmfa_mod.sv
// ----------------------------------------------------------------------------
// Pulse meter fill alarm serial remainder unit
// Restoring remainder of a 32-bit count by the 16-bit report divider,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
module pmfa_mod (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pmfa_pkg::CNT_W-1:0]    i_dividend,
    input  logic [pmfa_pkg::RDIV_W-1:0]   i_divisor,
    output logic                          o_done,
    output logic                          o_zero
);

    localparam int STEPS  = pmfa_pkg::CNT_W;
    localparam int STEP_W = $clog2(STEPS);
    localparam int REM_W  = pmfa_pkg::RDIV_W;

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [REM_W-1:0]  r_rem;
    logic [STEPS-1:0]  r_dvd;

    logic [REM_W:0]    w_shift;
    logic [REM_W:0]    w_sub;
    logic              w_ge;
    logic [REM_W-1:0]  n_rem;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        w_shift = {r_rem, r_dvd[STEPS-1]};
        w_ge    = (w_shift >= {1'b0, i_divisor});
        w_sub   = w_shift - {1'b0, i_divisor};
        n_rem   = w_ge ? w_sub[REM_W-1:0] : w_shift[REM_W-1:0];
    end

    // Step counter and remainder registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
            r_rem  <= '0;
            r_dvd  <= i_dividend;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_dvd  <= {r_dvd[STEPS-2:0], 1'b0};
            r_step <= r_step + 1'b1;
            if (r_step == STEP_W'(STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // The last step's remainder is ready in the cycle of done.
    assign o_done = r_busy && (r_step == STEP_W'(STEPS - 1));
    assign o_zero = (n_rem == '0);

endmodule

### rtl/core/pmfa_dp.sv
// ----------------------------------------------------------------------------
// Pulse meter fill alarm datapath
// Configuration registers, pulse counters, fill and alarm state, and the
// result register.
// ----------------------------------------------------------------------------
module pmfa_dp #(
    parameter int NUM_CHANNELS = pmfa_pkg::NUM_CHANNELS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pmfa_pkg::t_cmd                    i_cmd,
    output pmfa_pkg::t_sts                    o_sts,
    input  logic [pmfa_pkg::REQ_W-1:0]        i_req_type,
    input  logic [pmfa_pkg::CH_W-1:0]         i_channel,
    input  logic                              i_cfg_we,
    input  logic [pmfa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pmfa_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output logic                              o_report_due,
    output logic                              o_full_res,
    output logic                              o_beep_on,
    output logic [pmfa_pkg::CNT_W-1:0]        o_counts [pmfa_pkg::NUM_COUNT_FIELDS]
);

    localparam int CNT_W  = pmfa_pkg::CNT_W;
    localparam int CH_W   = pmfa_pkg::CH_W;
    localparam int BDIV_W = pmfa_pkg::BDIV_W;
    localparam int NCF    = pmfa_pkg::NUM_COUNT_FIELDS;

    // Configuration registers.
    logic [CH_W-1:0]             r_flow_ch;
    logic [pmfa_pkg::RDIV_W-1:0] r_rep_div;
    logic [pmfa_pkg::THR_W-1:0]  r_fill_thr;
    logic [BDIV_W-1:0]           r_beep_div;

    // Captured request.
    pmfa_pkg::t_req_type r_req;
    logic [CH_W-1:0]     r_ch;

    // Block state.
    logic [CNT_W-1:0]  r_counts [NUM_CHANNELS];
    logic              r_report_flag;
    logic              r_flow_seen;
    logic [CNT_W-1:0]  r_fill_now;
    logic [CNT_W-1:0]  r_fill_before;
    logic              r_full;
    logic              r_beep_phase;
    logic [BDIV_W-1:0] r_beep_step;
    logic              r_due;

    // Result register.
    logic              r_o_due;
    logic              r_o_full;
    logic              r_o_beep;
    logic [CNT_W-1:0]  r_o_counts [NCF];

    logic [NUM_CHANNELS-1:0] w_hit;
    logic                    w_ch_ok;
    logic                    w_flow_hit;
    logic [CNT_W-1:0]        w_sel_cnt;
    logic [CNT_W-1:0]        w_fill_inc;
    logic [BDIV_W-1:0]       w_bstep_inc;
    logic [BDIV_W-1:0]       w_bstep_nxt;
    logic                    w_btoggle;
    logic                    w_div_done;
    logic                    w_div_zero;
    logic [CNT_W-1:0]        w_cnt_src [NCF];

    // Channel decode and selection of the pulsed channel's count.
    always_comb begin
        w_sel_cnt = '0;
        for (int k = 0; k < NUM_CHANNELS; k++) begin
            w_hit[k] = (int'(r_ch) == k);
            if (w_hit[k]) begin
                w_sel_cnt = w_sel_cnt | r_counts[k];
            end
        end
        w_ch_ok    = (int'(r_ch) < NUM_CHANNELS);
        w_flow_hit = w_ch_ok && (r_ch == r_flow_ch);
    end

    // Saturating fill count and alarm pattern step.
    always_comb begin
        w_fill_inc  = (r_fill_now == '1) ? r_fill_now : r_fill_now + 1'b1;
        w_bstep_inc = r_beep_step + 1'b1;
        w_bstep_nxt = (w_bstep_inc > r_beep_div) ? '0 : w_bstep_inc;
        w_btoggle   = ((r_beep_div != '0) && (r_beep_step == r_beep_div - 1'b1))
                      || (r_beep_step == r_beep_div);
    end

    // A flow pulse with a nonzero divider needs the remainder check.
    assign o_sts.need_div = (r_req == pmfa_pkg::REQ_PULSE) && w_flow_hit
                            && (r_rep_div != '0);
    assign o_sts.div_done = w_div_done;

    pmfa_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.exec && o_sts.need_div),
        .i_dividend (w_sel_cnt + 1'b1),
        .i_divisor  (r_rep_div),
        .o_done     (w_div_done),
        .o_zero     (w_div_zero)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flow_ch  <= pmfa_pkg::RST_FLOW_CH;
            r_rep_div  <= pmfa_pkg::RST_REPORT_DIV;
            r_fill_thr <= pmfa_pkg::RST_FILL_THR;
            r_beep_div <= pmfa_pkg::RST_BEEP_DIV;
        end else if (i_cfg_we) begin
            unique case (pmfa_pkg::t_cfg_idx'(i_cfg_index))
                pmfa_pkg::CFG_FLOW_CH:    r_flow_ch  <= i_cfg_wdata[CH_W-1:0];
                pmfa_pkg::CFG_REPORT_DIV: r_rep_div  <= i_cfg_wdata[pmfa_pkg::RDIV_W-1:0];
                pmfa_pkg::CFG_FILL_THR:   r_fill_thr <= i_cfg_wdata[pmfa_pkg::THR_W-1:0];
                pmfa_pkg::CFG_BEEP_DIV:   r_beep_div <= i_cfg_wdata[BDIV_W-1:0];
                default: ;
            endcase
        end
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= pmfa_pkg::t_req_type'(i_req_type);
            r_ch  <= i_channel;
        end
    end

    // Counters: the pulsed channel increments, wrapping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r_counts[k] <= '0;
            end
        end else if (i_cmd.exec && (r_req == pmfa_pkg::REQ_PULSE)) begin
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                if (w_hit[k]) begin
                    r_counts[k] <= r_counts[k] + 1'b1;
                end
            end
        end
    end

    // Report flag, fill state and alarm pattern.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_report_flag <= 1'b0;
            r_flow_seen   <= 1'b0;
            r_fill_now    <= '0;
            r_fill_before <= '0;
            r_full        <= 1'b0;
            r_beep_phase  <= 1'b0;
            r_beep_step   <= '0;
            r_due         <= 1'b0;
        end else if (w_div_done) begin
            // The new flow count is a multiple of the divider.
            if (w_div_zero) begin
                r_report_flag <= 1'b1;
            end
        end else if (i_cmd.exec) begin
            r_due <= 1'b0;
            case (r_req)
                pmfa_pkg::REQ_PULSE: begin
                    if (w_flow_hit) begin
                        r_flow_seen <= 1'b1;
                        r_fill_now  <= w_fill_inc;
                    end else if (w_ch_ok) begin
                        r_report_flag <= 1'b1;
                    end
                end
                pmfa_pkg::REQ_UPDATE: begin
                    r_due         <= r_report_flag;
                    r_report_flag <= 1'b0;
                    if (r_fill_now != r_fill_before) begin
                        r_fill_before <= r_fill_now;
                        if (r_fill_now > {1'b0, r_fill_thr}) begin
                            r_full <= 1'b1;
                        end
                    end else if (r_flow_seen) begin
                        // Flow stopped after flowing: start over.
                        r_flow_seen   <= 1'b0;
                        r_fill_now    <= '0;
                        r_fill_before <= '0;
                        r_full        <= 1'b0;
                        r_beep_phase  <= 1'b0;
                        r_beep_step   <= '0;
                    end
                end
                pmfa_pkg::REQ_BEEP: begin
                    if (r_full) begin
                        r_beep_step  <= w_bstep_nxt;
                        r_beep_phase <= r_beep_phase ^ w_btoggle;
                    end else begin
                        r_beep_step  <= '0;
                        r_beep_phase <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Count fields of channels that do not exist read as zero.
    for (genvar g = 0; g < NCF; g++) begin : g_cnt_src
        if (g < NUM_CHANNELS) begin : g_real
            assign w_cnt_src[g] = r_counts[g];
        end else begin : g_none
            assign w_cnt_src[g] = '0;
        end
    end

    // Result register, loaded once the item is complete.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_o_due  <= r_due;
            r_o_full <= r_full;
            r_o_beep <= r_beep_phase;
            for (int k = 0; k < NCF; k++) begin
                r_o_counts[k] <= w_cnt_src[k];
            end
        end
    end

    assign o_report_due = r_o_due;
    assign o_full_res   = r_o_full;
    assign o_beep_on    = r_o_beep;
    assign o_counts     = r_o_counts;

endmodule

### rtl/core/pmfa_ctrl.sv
// ----------------------------------------------------------------------------
// Pulse meter fill alarm controller
// Sequences capture, execution, the remainder check and the result load,
// and owns the handshakes of the request and result channels.
// ----------------------------------------------------------------------------
module pmfa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  pmfa_pkg::t_sts i_sts,
    output pmfa_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_LOAD
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    // Commands decoded from the state.
    always_comb begin
        o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
        o_cmd.exec    = (r_state == S_EXEC);
        o_cmd.load    = (r_state == S_LOAD) && (!r_out_valid || i_out_ready);
    end

    // No request is taken while reset is held.
    assign o_in_ready  = (r_state == S_IDLE) && i_rst_n;
    assign o_out_valid = r_out_valid;

    // State and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // A taken result clears valid unless the next one loads now.
            if (r_out_valid && i_out_ready && !o_cmd.load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= i_sts.need_div ? S_DIV : S_LOAD;
                end
                S_DIV: begin
                    if (i_sts.div_done) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_capture_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == S_EXEC))
        else $error("captured request not executed next");

    a_exec_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> (r_state == S_DIV || r_state == S_LOAD))
        else $error("execution not followed by remainder check or load");

    a_div_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !i_sts.div_done) |=> (r_state == S_DIV))
        else $error("remainder check left before it finished");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == S_DIV))
        else $error("remainder unit finished outside its wait");

    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_LOAD))
        else $error("result valid raised without a load");
`endif

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pulse meter fill alarm testbench
// Drives pulses, update ticks, beep ticks and invalid requests through the
// request channel, with bursty requests and a stalling result receiver.
// A behavioral meter model predicts every result but those of the typed opening rows, and each
// result is checked field by field. The registers are rewritten between phases while idle.
// ----------------------------------------------------------------------------
module testbench;

    // Widths and codes taken from the package.
    localparam int REQ_W        = pmfa_pkg::REQ_W;
    localparam int CH_W         = pmfa_pkg::CH_W;
    localparam int CNT_W        = pmfa_pkg::CNT_W;
    localparam int RDIV_W       = pmfa_pkg::RDIV_W;
    localparam int THR_W        = pmfa_pkg::THR_W;
    localparam int BDIV_W       = pmfa_pkg::BDIV_W;
    localparam int CFG_DATA_W   = pmfa_pkg::CFG_DATA_W;
    localparam int NUM_CHANNELS = pmfa_pkg::NUM_CHANNELS;

    localparam logic [REQ_W-1:0] REQ_PULSE  = pmfa_pkg::REQ_PULSE;
    localparam logic [REQ_W-1:0] REQ_UPDATE = pmfa_pkg::REQ_UPDATE;
    localparam logic [REQ_W-1:0] REQ_BEEP   = pmfa_pkg::REQ_BEEP;
    // Request type with no meaning to the block.
    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
    localparam int NUM_PHASES = 10;
    localparam int PHASE_ITEMS = 100;
    localparam int SETTLE_CYCLES = 40;

    // One result of the meter.
    typedef struct packed {
        logic             report_due;
        logic             full_res;
        logic             beep_on;
        logic [CNT_W-1:0] count_a;
        logic [CNT_W-1:0] count_b;
        logic [CNT_W-1:0] count_c;
        logic [CNT_W-1:0] count_d;
        logic [CNT_W-1:0] count_e;
    } t_meter_result;

    // One row of the opening request list.
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic [CH_W-1:0]  ch;
        logic             fixed;
        t_meter_result    want;
    } t_probe_row;

    // Result fields side by side, each widened to a count.
    typedef logic [7:0][CNT_W-1:0] t_fields;

    // Stall behavior of the result receiver.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SLOW,
        RX_PATTERN
    } t_rx_mode;

    logic clk;
    logic rst_n;

    pmfa_req_if req_ch ();
    pmfa_res_if res_ch ();
    pmfa_cfg_if cfg_ch ();

    pulse_meter_fill_alarm dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // Meter model state, starting at its reset values.
    logic [CNT_W-1:0]  meter_count [NUM_CHANNELS];
    logic              report_pending = 1'b0;
    logic              flow_active    = 1'b0;
    logic [CNT_W-1:0]  fill_level     = '0;
    logic [CNT_W-1:0]  fill_last      = '0;
    logic              tank_full      = 1'b0;
    logic              alarm_phase    = 1'b0;
    logic [BDIV_W-1:0] alarm_step     = '0;

    // Model copy of the registers.
    logic [CH_W-1:0]   flow_ch_reg    = pmfa_pkg::RST_FLOW_CH;
    logic [RDIV_W-1:0] report_div_reg = pmfa_pkg::RST_REPORT_DIV;
    logic [THR_W-1:0]  fill_thr_reg   = pmfa_pkg::RST_FILL_THR;
    logic [BDIV_W-1:0] beep_div_reg   = pmfa_pkg::RST_BEEP_DIV;

    t_meter_result pending_readings [$];
    int            error_count  = 0;
    int            result_index = 0;
    int            burst_left   = 0;
    int            sent_items   = 0;

    t_rx_mode      rx_mode   = RX_OPEN;
    int            rx_cycles = 0;
    logic [7:0]    rx_pattern = 8'b1011_0010;

    // Opening requests at the reset register values. Rows with a typed result
    // are plain enough to read off by hand; the rest use the meter model.
    t_probe_row probe_rows [26] = '{
        // Update tick right after reset: nothing to report.
        '{REQ_UPDATE,  3'd0, 1'b1, '{1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}},
        // Invalid request type shows the state untouched.
        '{REQ_UNKNOWN, 3'd7, 1'b1, '{1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}},
        // Beep tick while not full.
        '{REQ_BEEP,    3'd0, 1'b1, '{1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}},
        // Pulses on channels that do not exist are ignored.
        '{REQ_PULSE,   3'd7, 1'b1, '{1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}},
        '{REQ_PULSE,   3'd5, 1'b1, '{1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}},
        // Pulses on ordinary channels; no report request outside update ticks.
        '{REQ_PULSE,   3'd4, 1'b1, '{1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1}},
        '{REQ_PULSE,   3'd1, 1'b1, '{1'b0, 1'b0, 1'b0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd1}},
        '{REQ_UPDATE,  3'd0, 1'b1, '{1'b1, 1'b0, 1'b0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd1}},
        '{REQ_UPDATE,  3'd3, 1'b1, '{1'b0, 1'b0, 1'b0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd1}},
        // Flow pulses, a fill step, then enough flow pulses to reach the divider.
        '{REQ_PULSE,   3'd0, 1'b0, '0},
        '{REQ_PULSE,   3'd0, 1'b0, '0},
        '{REQ_PULSE,   3'd2, 1'b0, '0},
        '{REQ_PULSE,   3'd3, 1'b0, '0},
        '{REQ_UPDATE,  3'd0, 1'b0, '0},
        '{REQ_BEEP,    3'd6, 1'b0, '0},
        '{REQ_PULSE,   3'd0, 1'b0, '0},
        '{REQ_PULSE,   3'd0, 1'b0, '0},
        '{REQ_PULSE,   3'd0, 1'b0, '0},
        '{REQ_PULSE,   3'd0, 1'b0, '0},
        '{REQ_PULSE,   3'd0, 1'b0, '0},
        '{REQ_PULSE,   3'd0, 1'b0, '0},
        '{REQ_PULSE,   3'd0, 1'b0, '0},
        '{REQ_PULSE,   3'd0, 1'b0, '0},
        '{REQ_UPDATE,  3'd0, 1'b0, '0},
        // Flow stopped after flowing: fill state clears.
        '{REQ_UPDATE,  3'd0, 1'b0, '0},
        '{REQ_UNKNOWN, 3'd0, 1'b0, '0}
    };

    // Register settings per phase; the last phase is drawn at random.
    logic [CH_W-1:0]   phase_flow_ch [NUM_PHASES] =
        '{3'd0, 3'd4, 3'd2, 3'd7, 3'd1, 3'd3, 3'd5, 3'd0, 3'd6, 3'd0};
    logic [RDIV_W-1:0] phase_rdiv [NUM_PHASES] =
        '{16'd1, 16'd0, 16'd3, 16'd65535, 16'd2, 16'd7, 16'd1, 16'd5, 16'd0, 16'd1};
    logic [THR_W-1:0]  phase_thr [NUM_PHASES] =
        '{31'd0, 31'd2, 31'h7FFF_FFFF, 31'd3, 31'd0, 31'd10, 31'd1, 31'd0, 31'd5, 31'd2};
    logic [BDIV_W-1:0] phase_bdiv [NUM_PHASES] =
        '{8'd1, 8'd0, 8'd2, 8'd3, 8'd255, 8'd4, 8'd0, 8'd5, 8'd1, 8'd2};

    string field_name [8] = '{"report_due", "full_res", "beep_on", "count_a",
                              "count_b", "count_c", "count_d", "count_e"};

    initial begin
        foreach (meter_count[k]) meter_count[k] = '0;
    end

    // Clock.
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Meter model: applies one request and returns the reading it gives.
    function automatic t_meter_result advance_meter(logic [REQ_W-1:0] req,
                                                    logic [CH_W-1:0] ch);
        t_meter_result    reading;
        logic [CNT_W-1:0] n;
        int unsigned      d;
        int unsigned      s;
        logic             due;
        due = 1'b0;
        if (req == REQ_PULSE) begin
            if (ch < NUM_CHANNELS) begin
                n = meter_count[ch] + 32'd1;
                meter_count[ch] = n;
                if (ch == flow_ch_reg) begin
                    flow_active = 1'b1;
                    if (fill_level != '1) fill_level = fill_level + 32'd1;
                    if (report_div_reg != '0 && (n % {16'd0, report_div_reg}) == '0)
                        report_pending = 1'b1;
                end else begin
                    report_pending = 1'b1;
                end
            end
        end else if (req == REQ_UPDATE) begin
            if (fill_level != fill_last) begin
                fill_last = fill_level;
                if (fill_level > {1'b0, fill_thr_reg}) tank_full = 1'b1;
            end else if (flow_active) begin
                flow_active = 1'b0;
                fill_level  = '0;
                fill_last   = '0;
                tank_full   = 1'b0;
                alarm_step  = '0;
                alarm_phase = 1'b0;
            end
            due = report_pending;
            report_pending = 1'b0;
        end else if (req == REQ_BEEP) begin
            d = 32'(beep_div_reg);
            s = 32'(alarm_step);
            if ((d != 0 && s == d - 1) || s == d) alarm_phase = ~alarm_phase;
            s = (s + 1) & 32'hFF;
            if (s > d) s = 0;
            alarm_step = s[BDIV_W-1:0];
            if (!tank_full) begin
                alarm_step  = '0;
                alarm_phase = 1'b0;
            end
        end
        reading.report_due = due;
        reading.full_res   = tank_full;
        reading.beep_on    = alarm_phase;
        reading.count_a    = meter_count[0];
        reading.count_b    = meter_count[1];
        reading.count_c    = meter_count[2];
        reading.count_d    = meter_count[3];
        reading.count_e    = meter_count[4];
        return reading;
    endfunction

    function automatic t_fields reading_fields(t_meter_result r);
        t_fields f;
        f[0] = {31'd0, r.report_due};
        f[1] = {31'd0, r.full_res};
        f[2] = {31'd0, r.beep_on};
        f[3] = r.count_a;
        f[4] = r.count_b;
        f[5] = r.count_c;
        f[6] = r.count_d;
        f[7] = r.count_e;
        return f;
    endfunction

    // Sends one request in the current burst. Called at a falling edge and
    // returns at a falling edge; valid stays high while the burst goes on.
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [CH_W-1:0] ch,
                                input logic fixed, input t_meter_result want);
        t_meter_result reading;
        req_ch.valid    = 1'b1;
        req_ch.req_type = req;
        req_ch.channel  = ch;
        do @(posedge clk); while (!req_ch.ready);
        reading = advance_meter(req, ch);
        pending_readings.push_back(fixed ? want : reading);
        sent_items++;
        @(negedge clk);
        if (burst_left == 0) begin
            req_ch.valid    = 1'b0;
            req_ch.req_type = REQ_W'($urandom);
            req_ch.channel  = CH_W'($urandom);
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 12);
        end else begin
            burst_left--;
        end
    endtask

    // Writes one register; the caller lowers valid after the last write.
    task automatic write_register(input pmfa_pkg::t_cfg_idx idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid     = 1'b1;
        cfg_ch.reg_index = idx;
        cfg_ch.wdata     = value;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            pmfa_pkg::CFG_FLOW_CH:    flow_ch_reg    = value[CH_W-1:0];
            pmfa_pkg::CFG_REPORT_DIV: report_div_reg = value[RDIV_W-1:0];
            pmfa_pkg::CFG_FILL_THR:   fill_thr_reg   = value[THR_W-1:0];
            pmfa_pkg::CFG_BEEP_DIV:   beep_div_reg   = value[BDIV_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Closes the current burst and waits until every reading is back.
    task automatic drain_requests();
        req_ch.valid = 1'b0;
        while (pending_readings.size() != 0) @(negedge clk);
    endtask

    // Result receiver: the stall behavior is redrawn at random from four modes.
    always @(negedge clk) begin
        if (rx_cycles == 0) begin
            rx_mode   = t_rx_mode'($urandom_range(0, 3));
            rx_cycles = $urandom_range(16, 200);
        end else begin
            rx_cycles--;
        end
        case (rx_mode)
            RX_OPEN:    res_ch.ready = 1'b1;
            RX_COIN:    res_ch.ready = 1'($urandom_range(0, 1));
            RX_SLOW:    res_ch.ready = ($urandom_range(0, 3) == 0);
            RX_PATTERN: res_ch.ready = rx_pattern[rx_cycles % 8];
            default:    res_ch.ready = 1'b1;
        endcase
    end

    // Result check against the oldest outstanding reading.
    always @(posedge clk) begin : result_check
        t_meter_result got;
        t_meter_result want;
        t_fields       got_f;
        t_fields       want_f;
        logic          bad;
        if (res_ch.valid && res_ch.ready) begin
            got.report_due = res_ch.report_due;
            got.full_res   = res_ch.full_res;
            got.beep_on    = res_ch.beep_on;
            got.count_a    = res_ch.count_a;
            got.count_b    = res_ch.count_b;
            got.count_c    = res_ch.count_c;
            got.count_d    = res_ch.count_d;
            got.count_e    = res_ch.count_e;
            if (pending_readings.size() == 0) begin
                if (error_count < 10)
                    $display("result %0d arrived with no request outstanding", result_index);
                error_count++;
            end else begin
                want   = pending_readings.pop_front();
                got_f  = reading_fields(got);
                want_f = reading_fields(want);
                bad    = 1'b0;
                for (int f = 0; f < 8; f++) begin
                    if (got_f[f] !== want_f[f]) begin
                        if (error_count < 10)
                            $display("result %0d: %s expected %0h, got %0h",
                                     result_index, field_name[f], want_f[f], got_f[f]);
                        bad = 1'b1;
                    end
                end
                if (bad) error_count++;
            end
            result_index++;
        end
    end

    // Stimulus.
    initial begin : stimulus
        int                  reps;
        int                  beeps;
        int                  goal;
        logic [CH_W-1:0]     ch;
        logic [CH_W-1:0]     p_flow;
        logic [RDIV_W-1:0]   p_rdiv;
        logic [THR_W-1:0]    p_thr;
        logic [BDIV_W-1:0]   p_bdiv;

        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = REQ_PULSE;
        req_ch.channel   = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.reg_index = pmfa_pkg::CFG_FLOW_CH;
        cfg_ch.wdata     = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Opening requests at the reset register values.
        foreach (probe_rows[r])
            send_request(probe_rows[r].req, probe_rows[r].ch, probe_rows[r].fixed,
                         probe_rows[r].want);

        // Random phases, each under its own register setting.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain_requests();
            p_flow = phase_flow_ch[phase];
            p_rdiv = phase_rdiv[phase];
            p_thr  = phase_thr[phase];
            p_bdiv = phase_bdiv[phase];
            if (phase == NUM_PHASES - 1) begin
                p_flow = CH_W'($urandom_range(0, 7));
                p_rdiv = RDIV_W'($urandom_range(0, 65535));
                p_thr  = THR_W'($urandom_range(0, 40));
                p_bdiv = BDIV_W'($urandom_range(0, 255));
            end
            // Bits above each register's width carry junk that must be dropped.
            write_register(pmfa_pkg::CFG_FLOW_CH,
                           ($urandom & 32'hFFFF_FFF8) | 32'(p_flow));
            write_register(pmfa_pkg::CFG_REPORT_DIV,
                           ($urandom & 32'hFFFF_0000) | 32'(p_rdiv));
            write_register(pmfa_pkg::CFG_FILL_THR,
                           ($urandom & 32'h8000_0000) | 32'(p_thr));
            write_register(pmfa_pkg::CFG_BEEP_DIV,
                           ($urandom & 32'hFFFF_FF00) | 32'(p_bdiv));
            cfg_ch.valid = 1'b0;

            goal = sent_items + PHASE_ITEMS;
            while (sent_items < goal) begin
                if ($urandom_range(0, 9) < 8) begin
                    // Filling run: flow pulses before every update tick keep
                    // the fill growing, beep ticks run the alarm pattern, and
                    // update ticks without flow end the run.
                    reps = $urandom_range(1, 6);
                    repeat (reps) begin
                        repeat ($urandom_range(1, 4)) begin
                            ch = ($urandom_range(0, 9) < 7) ? flow_ch_reg
                                                            : CH_W'($urandom_range(0, 7));
                            send_request(REQ_PULSE, ch, 1'b0, '0);
                        end
                        if ($urandom_range(0, 2) == 0)
                            send_request(REQ_PULSE, CH_W'($urandom_range(0, 7)), 1'b0, '0);
                        send_request(REQ_UPDATE, CH_W'($urandom), 1'b0, '0);
                        beeps = (beep_div_reg > 8'd8 && $urandom_range(0, 3) == 0)
                              ? int'(beep_div_reg) + 2 : $urandom_range(0, 6);
                        repeat (beeps) send_request(REQ_BEEP, CH_W'($urandom), 1'b0, '0);
                        if ($urandom_range(0, 7) == 0)
                            send_request(REQ_UNKNOWN, CH_W'($urandom), 1'b0, '0);
                    end
                    repeat ($urandom_range(1, 2))
                        send_request(REQ_UPDATE, CH_W'($urandom), 1'b0, '0);
                end else begin
                    // Noise: any request type on any channel.
                    repeat ($urandom_range(3, 10))
                        send_request(REQ_W'($urandom_range(0, 3)),
                                     CH_W'($urandom_range(0, 7)), 1'b0, '0);
                end
            end
        end

        drain_requests();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_readings.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // Run limit.
    initial begin
        #10ms;
        $display("testbench failed");
        $finish;
    end

endmodule
